// File: design/ifd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ifd_pkg;

  localparam int DATA_W = 64;
  localparam int STAT_W = 2;
  localparam int ET_W   = 3;

  typedef enum logic [ET_W-1:0] {
    ET_U8  = 3'd0,
    ET_I8  = 3'd1,
    ET_I16 = 3'd2,
    ET_I32 = 3'd3,
    ET_I64 = 3'd4
  } elem_type_t;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DZ  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF = 2'd2;

  // per-item flags carried from the front part to the back part
  typedef struct packed {
    logic neg_q;  // operand signs differ
    logic sext;   // signed element type
    logic dz;     // divisor is zero
  } meta_t;

endpackage
`default_nettype wire

// File: design/ifd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ifd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_pop,
  output logic      [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("fifo count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("fifo count lost a push");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop) else $error("fifo pop while empty");
`endif

endmodule
`default_nettype wire

// File: design/ifd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ifd_front
  import ifd_pkg::*;
#(
  parameter int MW = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ET_W-1:0]   cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [MW-1:0]     out_ma,
  output logic      [MW-1:0]     out_mb,
  output logic      [MW-1:0]     out_mask,
  output meta_t                  out_meta
);

  elem_type_t      elem_type;
  logic [6:0]      typew;
  logic [6:0]      w;
  logic            sext;
  logic [MW-1:0]   mask;
  logic [MW-1:0]   topb;
  logic [MW-1:0]   a;
  logic [MW-1:0]   b;
  logic [MW-1:0]   sa;
  logic [MW-1:0]   sb;
  logic            neg_a;
  logic            neg_b;
  logic            take;

  // element type register
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_type <= ET_I64;
    end else if (cfg_we) begin
      elem_type <= elem_type_t'(cfg_wdata);
    end
  end

  // element width and signedness
  always_comb begin
    sext = 1'b1;
    case (elem_type)
      ET_U8: begin
        typew = 7'd8;
        sext  = 1'b0;
      end
      ET_I8:   typew = 7'd8;
      ET_I16:  typew = 7'd16;
      ET_I32:  typew = 7'd32;
      default: typew = 7'd64;
    endcase
    w = (typew > 7'(MW)) ? 7'(MW) : typew;
    for (int i = 0; i < MW; i++) begin
      mask[i] = (7'(i) < w);
    end
  end

  // masked operands, sign and magnitude
  always_comb begin
    topb  = mask ^ (mask >> 1);
    a     = dividend[MW-1:0] & mask;
    b     = divisor[MW-1:0] & mask;
    neg_a = sext && ((a & topb) != '0);
    neg_b = sext && ((b & topb) != '0);
    sa    = neg_a ? (a | ~mask) : a;
    sb    = neg_b ? (b | ~mask) : b;
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // classified item register
  always_ff @(posedge clk) begin
    if (take) begin
      out_ma         <= neg_a ? (MW'(0) - sa) : sa;
      out_mb         <= neg_b ? (MW'(0) - sb) : sb;
      out_mask       <= mask;
      out_meta.neg_q <= neg_a ^ neg_b;
      out_meta.sext  <= sext;
      out_meta.dz    <= (b == '0);
    end
  end

endmodule
`default_nettype wire

// File: design/ifd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ifd_back
  import ifd_pkg::*;
#(
  parameter int MW = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_pop,
  input  wire logic [MW-1:0]     in_ma,
  input  wire logic [MW-1:0]     in_mb,
  input  wire logic [MW-1:0]     in_mask,
  input  wire meta_t             in_meta,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_quot,
  output logic      [STAT_W-1:0] out_status
);

  logic          en;
  logic          vld_s  [0:MW];
  logic [MW-1:0] rem_s  [0:MW];
  logic [MW-1:0] num_s  [0:MW];
  logic [MW-1:0] den_s  [0:MW];
  logic [MW-1:0] msk_s  [0:MW];
  meta_t         meta_s [0:MW];

  // whole pipe moves unless the output register is held
  assign en     = !out_valid || out_ready;
  assign in_pop = en && in_valid;

  assign vld_s[0]  = in_valid;
  assign rem_s[0]  = '0;
  assign num_s[0]  = in_ma;
  assign den_s[0]  = in_mb;
  assign msk_s[0]  = in_mask;
  assign meta_s[0] = in_meta;

  // one restoring quotient bit per stage
  for (genvar g = 0; g < MW; g++) begin : g_stage
    logic [MW:0] tmp;
    logic [MW:0] diff;
    logic        ge;

    assign tmp  = {rem_s[g], num_s[g][MW-1]};
    assign diff = tmp - {1'b0, den_s[g]};
    assign ge   = (tmp >= {1'b0, den_s[g]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else if (en) begin
        vld_s[g+1] <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1]  <= ge ? diff[MW-1:0] : tmp[MW-1:0];
        num_s[g+1]  <= {num_s[g][MW-2:0], ge};
        den_s[g+1]  <= den_s[g];
        msk_s[g+1]  <= msk_s[g];
        meta_s[g+1] <= meta_s[g];
      end
    end
  end

  // floor correction, wrap check and extension to the field width
  logic [MW-1:0]     qm;
  logic [MW-1:0]     q;
  logic [MW-1:0]     qmask;
  logic [MW-1:0]     limit;
  logic              qsign;
  logic [DATA_W-1:0] q64;
  logic [STAT_W-1:0] st;

  always_comb begin
    qm    = num_s[MW];
    limit = msk_s[MW] >> 1;
    if (meta_s[MW].neg_q) begin
      q = MW'(0) - qm - MW'(rem_s[MW] != '0);
    end else begin
      q = qm;
    end
    qmask = q & msk_s[MW];
    qsign = meta_s[MW].sext && ((qmask & (msk_s[MW] ^ limit)) != '0);
    q64   = DATA_W'(qmask) | (qsign ? ~DATA_W'(msk_s[MW]) : '0);
    st    = ST_OK;
    if (meta_s[MW].dz) begin
      q64 = '0;
      st  = ST_DZ;
    end else if (meta_s[MW].sext && !meta_s[MW].neg_q && (qm > limit)) begin
      st  = ST_OVF;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_s[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quot   <= q64;
      out_status <= st;
    end
  end

endmodule
`default_nettype wire

// File: design/integer_floor_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | signals                         | contents
// s_axis    | in  | tvalid, tready, tdata[127:0]    | dividend, divisor
// m_axis    | out | tvalid, tready, tdata, tuser    | quotient, status
// cfg       | in  | cfg_we, cfg_wdata[2:0]          | element type
//
// one item per cycle sustained while m_axis accepts; items pass the front register,
// the queue, the MAX_WIDTH-stage bit-per-stage divider and the output register.
// rst is synchronous and active high; the element type resets to int64.
// a stall on m_axis holds the divider pipe; s_axis keeps taking items until
// the front register and the two-entry queue are full.
module integer_floor_divider
  import ifd_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [ET_W-1:0]     cfg_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [2*DATA_W-1:0] s_axis_tdata,   // dividend[63:0], divisor[127:64]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [DATA_W-1:0]   m_axis_tdata,   // quotient[63:0]
  output logic      [STAT_W-1:0]   m_axis_tuser    // status[1:0]
);

  localparam int MW   = MAX_WIDTH;
  localparam int QW   = 3 * MW + $bits(meta_t);

  logic          f_valid;
  logic          f_ready;
  logic [MW-1:0] f_ma;
  logic [MW-1:0] f_mb;
  logic [MW-1:0] f_mask;
  meta_t         f_meta;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_data;
  meta_t         q_meta;

  ifd_front #(.MW(MW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dividend  (s_axis_tdata[DATA_W-1:0]),
    .divisor   (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_ma    (f_ma),
    .out_mb    (f_mb),
    .out_mask  (f_mask),
    .out_meta  (f_meta)
  );

  // queue between classification and the divider pipe
  ifd_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_meta, f_mask, f_mb, f_ma}),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  assign q_meta = meta_t'(q_data[QW-1:3*MW]);

  ifd_back #(.MW(MW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_pop     (q_pop),
    .in_ma      (q_data[MW-1:0]),
    .in_mb      (q_data[2*MW-1:MW]),
    .in_mask    (q_data[3*MW-1:2*MW]),
    .in_meta    (q_meta),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_quot   (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_DZ) |-> m_axis_tdata == '0)
    else $error("divide by zero item with nonzero quotient");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_DZ ||
                       m_axis_tuser == ST_OVF))
    else $error("undefined status code");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("result right after reset");
`endif

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import ifd_pkg::*;

  localparam int LATENCY   = 64 + 3;
  localparam int STALL_MAX = 2000;
  localparam int N_RANDOM  = 550;

  typedef struct packed {
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] dividend;
  } operands_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [STAT_W-1:0] status;
  } quot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ET_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2*DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  integer_floor_divider uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  operands_t pending_ops[$];
  quot_t expected_quots[$];
  logic [ET_W-1:0] cur_type = ET_I64;
  logic idle_free = 1'b0;
  logic in_taken = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_dz = 0;
  int n_ovf = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] sext_w(logic [63:0] v, int w);
    logic [63:0] m;
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    v = v & m;
    if (w < 64 && v[w-1]) v = v | ~m;
    return v;
  endfunction

  // floor division under the current element type
  function automatic quot_t floor_div(logic [ET_W-1:0] et, operands_t op);
    quot_t r;
    int w;
    logic sgn;
    logic [63:0] m, a, b, sa, sb, ma, mb, qm, rm, q;
    sgn = 1'b1;
    case (et)
      ET_U8: begin w = 8; sgn = 1'b0; end
      ET_I8: w = 8;
      ET_I16: w = 16;
      ET_I32: w = 32;
      default: w = 64;
    endcase
    m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    a = op.dividend & m;
    b = op.divisor & m;
    r.status = ST_OK;
    if (b == 0) begin
      r.quotient = '0;
      r.status = ST_DZ;
    end else if (!sgn) begin
      r.quotient = (a / b) & m;
    end else begin
      sa = sext_w(a, w);
      sb = sext_w(b, w);
      ma = sa[63] ? -sa : sa;
      mb = sb[63] ? -sb : sb;
      qm = ma / mb;
      rm = ma % mb;
      if (sa[63] != sb[63]) begin
        q = -qm;
        if (rm != 0) q = q - 64'd1;
      end else begin
        q = qm;
        if (qm > (m >> 1)) r.status = ST_OVF;
      end
      r.quotient = sext_w(q & m, w);
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
      3: v = 64'(signed'($urandom_range(0, 20)) - 10);
      4: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // driver: present pending items, idle at random
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (pending_ops.size() > 0 && (idle_free || $urandom_range(0, 99) >= 36)) begin
          s_axis_tdata <= pending_ops[0];
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= idle_free || ($urandom_range(0, 99) >= 36);
    end
  end

  // input acceptance: predict the result
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_quots.push_back(floor_div(cur_type, operands_t'(s_axis_tdata)));
      void'(pending_ops.pop_front());
      in_taken = 1'b1;
      n_sent++;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    quot_t exp_q;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_recv++;
      if (expected_quots.size() == 0) begin
        $display("%0t: unexpected item quotient=%h status=%0d", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        exp_q = expected_quots.pop_front();
        if (exp_q.status == ST_DZ) n_dz++;
        if (exp_q.status == ST_OVF) n_ovf++;
        if (m_axis_tdata !== exp_q.quotient) begin
          $display("%0t: quotient mismatch expected %h actual %h", $time, exp_q.quotient,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp_q.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time, exp_q.status,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_quots.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_type(logic [ET_W-1:0] et);
    @(negedge clk);
    cfg_wdata <= et;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_type = et;
  endtask

  task automatic push_op(logic [63:0] a, logic [63:0] b);
    operands_t op;
    op.dividend = a;
    op.divisor = b;
    pending_ops.push_back(op);
  endtask

  initial begin
    logic [ET_W-1:0] et;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset type int64 extremes, division by zero, overflow
    push_op(64'h8000_0000_0000_0000, '1);
    push_op(64'h7fff_ffff_ffff_ffff, 64'd1);
    push_op(64'h7fff_ffff_ffff_ffff, '1);
    push_op(64'd7, 64'd0);
    push_op(-64'd7, 64'd2);
    push_op(64'd7, -64'd2);
    push_op(-64'd7, -64'd2);
    push_op(-64'd8, 64'd2);
    push_op('0, 64'h8000_0000_0000_0000);
    drain();
    // narrow types, upper bits must be ignored
    set_type(ET_I8);
    push_op(64'hffff_ffff_ffff_ff80, 64'h1234_5678_9abc_deff);
    push_op(64'h0000_0000_0000_007f, 64'hffff_ffff_ffff_ff80);
    push_op(64'hffff_ffff_ffff_ff81, 64'h0000_0000_0000_0100);
    drain();
    set_type(ET_U8);
    push_op(64'hffff_ffff_ffff_ffff, 64'h01);
    push_op(64'h0000_0000_0000_00ff, 64'hff);
    push_op(64'h80, 64'h7);
    drain();
    set_type(ET_I16);
    push_op(64'h8000, 64'hffff);
    push_op(64'h8001, 64'h3);
    drain();
    set_type(ET_I32);
    push_op(64'h8000_0000, 64'hffff_ffff);
    push_op(64'h7fff_ffff, 64'hffff_fffe);
    drain();
    set_type(3'd7);
    push_op(64'h8000_0000_0000_0000, '1);
    push_op(-64'd9, 64'd4);
    drain();

    // random phases over all types, including unused selectors
    for (int ph = 0; ph < 11; ph++) begin
      et = (ph < 8) ? ET_W'(ph) : ET_W'($urandom_range(0, 4));
      set_type(et);
      idle_free = (ph == 4);
      for (int i = 0; i < N_RANDOM / 11; i++)
        push_op(rand64(), rand64());
      drain();
    end
    set_type(ET_U8);
    set_type(ET_I64);

    $display("%0d items sent, %0d results checked (%0d divide by zero, %0d overflow)",
             n_sent, n_recv, n_dz, n_ovf);
    $display("all element types and unused selectors exercised with random backpressure");
    if (errors == 0 && expected_quots.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
